>>> rtl/bbc_pkg.sv
package bbc_pkg;

    // Stack capacity in brackets; the level counter and RAM address follow from it.
    localparam int DEPTH  = 64;
    localparam int LVL_W  = $clog2(DEPTH + 1);
    localparam int ADDR_W = $clog2(DEPTH);

    // Status codes
    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_BALANCED = 3'd1;
    localparam logic [2:0] ST_MISMATCH = 3'd2;
    localparam logic [2:0] ST_EMPTY    = 3'd3;
    localparam logic [2:0] ST_UNCLOSED = 3'd4;
    localparam logic [2:0] ST_OVERFLOW = 3'd5;

    // Bracket kinds as stored on the stack
    localparam logic [1:0] KIND_CURLY  = 2'd0;
    localparam logic [1:0] KIND_SQUARE = 2'd1;
    localparam logic [1:0] KIND_ROUND  = 2'd2;

    localparam logic [7:0] CH_LCURLY  = 8'h7B;
    localparam logic [7:0] CH_RCURLY  = 8'h7D;
    localparam logic [7:0] CH_LSQUARE = 8'h5B;
    localparam logic [7:0] CH_RSQUARE = 8'h5D;
    localparam logic [7:0] CH_LROUND  = 8'h28;
    localparam logic [7:0] CH_RROUND  = 8'h29;

    typedef struct packed {
        logic       is_bracket;
        logic       opening;
        logic [1:0] kind;
    } char_class_t;

    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
        logic [1:0]        data;
    } ram_wr_t;

    function automatic char_class_t classify(input logic [7:0] ch);
        char_class_t c;
        c = '{is_bracket: 1'b1, opening: 1'b0, kind: KIND_CURLY};
        case (ch)
            CH_LCURLY:  begin c.opening = 1'b1; c.kind = KIND_CURLY;  end
            CH_RCURLY:  begin c.kind = KIND_CURLY;  end
            CH_LSQUARE: begin c.opening = 1'b1; c.kind = KIND_SQUARE; end
            CH_RSQUARE: begin c.kind = KIND_SQUARE; end
            CH_LROUND:  begin c.opening = 1'b1; c.kind = KIND_ROUND;  end
            CH_RROUND:  begin c.kind = KIND_ROUND;  end
            default:    c.is_bracket = 1'b0;
        endcase
        return c;
    endfunction

endpackage

>>> rtl/bracket_balance_checker_core.sv
// Channel  | Direction | Handshake            | Payload
// ---------+-----------+----------------------+----------------------------------
// request  | in        | in_valid / in_ready  | char_code[7:0], is_last
// result   | out       | out_valid / out_ready| status[2:0], string_done, open_depth[6:0]
//
// One request per cycle unless a result waits untaken; one result per request,
// registered and shown in the cycle after its request is taken. The stack's top
// entry lives in a register; the one below is prefetched from the RAM every cycle.
// Reset (rst_n, async, active low) clears level, error and output valid; the
// RAM holds no reset state and needs no clearing pass.
// A stalled result holds its register; a new request is taken in the same
// cycle the waiting result is taken.
module bracket_balance_checker_core (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] char_code,
    input  logic       is_last,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [2:0] status,
    output logic       string_done,
    output logic [6:0] open_depth
);
    import bbc_pkg::*;

    // Stack control state
    logic [LVL_W-1:0]  level_reg, level_next;
    logic [2:0]        err_reg, err_next;
    logic [1:0]        tos_reg, tos_next;

    // Bypass for a read that collides with the write of the same cycle
    logic              fwd_reg, fwd_next;
    logic [1:0]        fwd_data_reg;

    // Output register
    logic              out_valid_reg;
    logic [2:0]        status_reg, status_next;
    logic              done_reg;
    logic [6:0]        depth_reg;

    logic              accept;
    char_class_t       cls;
    ram_wr_t           wr;
    logic [ADDR_W-1:0] rd_addr;
    logic [1:0]        rd_data;
    logic [1:0]        below;
    logic [LVL_W-1:0]  level_step;
    logic [2:0]        err_step;
    logic [LVL_W-1:0]  level_m1;
    logic [LVL_W-1:0]  level_m2;

    bbc_stack_ram u_ram (
        .clk     (clk),
        .wr      (wr),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign in_ready = !out_valid_reg || out_ready;
    assign accept   = in_valid && in_ready;
    assign cls      = classify(char_code);

    // Entry just under the top of stack, valid whenever the level is two or more.
    assign below    = fwd_reg ? fwd_data_reg : rd_data;
    assign level_m1 = level_reg - LVL_W'(1);

    always_comb
    begin
        level_step = level_reg;
        err_step   = err_reg;
        tos_next   = tos_reg;
        wr         = '{en: 1'b0, addr: level_m1[ADDR_W-1:0], data: tos_reg};

        if (accept && err_reg == ST_OK && cls.is_bracket)
        begin
            if (cls.opening)
            begin
                if (level_reg >= LVL_W'(DEPTH))
                begin
                    err_step = ST_OVERFLOW;
                end
                else
                begin
                    // spill the old top into the RAM, new kind becomes the top
                    wr.en      = (level_reg != '0);
                    tos_next   = cls.kind;
                    level_step = level_reg + LVL_W'(1);
                end
            end
            else if (level_reg == '0)
            begin
                err_step = ST_EMPTY;
            end
            else
            begin
                // pop: compare with the top, promote the prefetched entry
                level_step = level_m1;
                tos_next   = below;
                if (tos_reg != cls.kind)
                begin
                    err_step = ST_MISMATCH;
                end
            end
        end

        if (err_step != ST_OK)
        begin
            status_next = err_step;
        end
        else if (is_last)
        begin
            status_next = (level_step == '0) ? ST_BALANCED : ST_UNCLOSED;
        end
        else
        begin
            status_next = ST_OK;
        end

        // end of string: drop the stack and the held error
        if (accept && is_last)
        begin
            level_next = '0;
            err_next   = ST_OK;
        end
        else
        begin
            level_next = level_step;
            err_next   = err_step;
        end

        // prefetch the entry that will sit under the next top
        level_m2 = level_next - LVL_W'(2);
        rd_addr  = level_m2[ADDR_W-1:0];
        fwd_next = wr.en && (wr.addr == rd_addr);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            level_reg     <= '0;
            err_reg       <= ST_OK;
            fwd_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            level_reg <= level_next;
            err_reg   <= err_next;
            fwd_reg   <= fwd_next;
            if (accept)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers, no reset
    always_ff @(posedge clk)
    begin
        tos_reg      <= tos_next;
        fwd_data_reg <= wr.data;
        if (accept)
        begin
            status_reg <= status_next;
            done_reg   <= is_last;
            depth_reg  <= 7'(level_step);
        end
    end

    assign out_valid   = out_valid_reg;
    assign status      = status_reg;
    assign string_done = done_reg;
    assign open_depth  = depth_reg;

    // Level never runs past the stack capacity.
    a_level_bound: assert property (@(posedge clk) disable iff (!rst_n)
        level_reg <= LVL_W'(DEPTH))
        else $error("stack level above capacity");

    // A last request leaves the block cleared for the next string.
    a_clear_on_last: assert property (@(posedge clk) disable iff (!rst_n)
        accept && is_last |=> level_reg == '0 && err_reg == ST_OK)
        else $error("state not cleared after end of string");

    // A held error freezes the stack level until the string ends.
    a_error_freeze: assert property (@(posedge clk) disable iff (!rst_n)
        err_reg != ST_OK && !(accept && is_last) |=>
            level_reg == $past(level_reg) && err_reg == $past(err_reg))
        else $error("stack moved while an error was held");

    // Every accepted request produces a result in the next cycle.
    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> out_valid)
        else $error("result missing after accepted request");

endmodule

>>> rtl/bbc_stack_ram.sv
module bbc_stack_ram (
    input  logic                       clk,
    input  bbc_pkg::ram_wr_t           wr,
    input  logic [bbc_pkg::ADDR_W-1:0] rd_addr,
    output logic [1:0]                 rd_data
);
    import bbc_pkg::*;

    logic [1:0] mem [DEPTH];

    // One write port, one read port, read data registered (old data on collision).
    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr.data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

>>> bench/tb.sv
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import bbc_pkg::*;

    typedef logic [7:0] char_q_t[$];

    typedef struct {
        logic [2:0] status;
        logic       done;
        logic [6:0] depth;
    } bbc_result_t;

    logic       clk;
    logic       rst_n;
    logic       in_valid;
    logic       in_ready;
    logic [7:0] char_code;
    logic       is_last;
    logic       out_valid;
    logic       out_ready;
    logic [2:0] status;
    logic       string_done;
    logic [6:0] open_depth;

    // Predicted results, oldest first, one per accepted request.
    bbc_result_t expected_results[$];

    // Shadow copy of the bracket stack and the held error.
    logic [1:0] bracket_stack [DEPTH];
    int         open_level;
    logic [2:0] held_error;

    // Idle rates in percent per cycle, changed from phase to phase.
    int send_idle_pct;
    int recv_stall_pct;

    int fail_count;

    bracket_balance_checker_core dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .char_code   (char_code),
        .is_last     (is_last),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .status      (status),
        .string_done (string_done),
        .open_depth  (open_depth)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Hard stop in case the block hangs or drops a result.
    initial
    begin
        #2_000_000;
        $display("tb failed");
        $finish;
    end

    // Work out the result of one accepted request and advance the shadow state.
    // Once an error is held, every later character of the string is dropped and
    // the error is repeated; the last character reports and clears everything.
    function automatic void predict_result(input logic [7:0] ch, input logic last);
        logic        bracket;
        logic        opening;
        logic [1:0]  kind;
        bbc_result_t r;
        bracket = 1'b1;
        opening = 1'b0;
        kind    = KIND_CURLY;
        case (ch)
            CH_LCURLY:  begin opening = 1'b1; kind = KIND_CURLY;  end
            CH_RCURLY:  kind = KIND_CURLY;
            CH_LSQUARE: begin opening = 1'b1; kind = KIND_SQUARE; end
            CH_RSQUARE: kind = KIND_SQUARE;
            CH_LROUND:  begin opening = 1'b1; kind = KIND_ROUND;  end
            CH_RROUND:  kind = KIND_ROUND;
            default:    bracket = 1'b0;
        endcase

        if (held_error == ST_OK && bracket)
        begin
            if (opening)
            begin
                // A full stack refuses the push and holds an overflow.
                if (open_level >= DEPTH)
                    held_error = ST_OVERFLOW;
                else
                begin
                    bracket_stack[open_level] = kind;
                    open_level++;
                end
            end
            else if (open_level == 0)
                held_error = ST_EMPTY;
            else
            begin
                // Pop even when the kinds disagree.
                open_level--;
                if (bracket_stack[open_level] != kind)
                    held_error = ST_MISMATCH;
            end
        end

        if (held_error != ST_OK)
            r.status = held_error;
        else if (last)
            r.status = (open_level == 0) ? ST_BALANCED : ST_UNCLOSED;
        else
            r.status = ST_OK;
        r.done  = last;
        r.depth = 7'(open_level);
        expected_results.push_back(r);

        if (last)
        begin
            open_level = 0;
            held_error = ST_OK;
        end
    endfunction

    // Offer one request, idling first at the current rate; hold it until taken.
    task automatic send_char(input logic [7:0] ch, input logic last);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid  <= 1'b1;
        char_code <= ch;
        is_last   <= last;
        do
            @(posedge clk);
        while (!in_ready);
        predict_result(ch, last);
    endtask

    // Send a whole string; the final character carries the last mark.
    task automatic send_string(input char_q_t text);
        for (int i = 0; i < text.size(); i++)
            send_char(text[i], i == text.size() - 1);
    endtask

    task automatic send_text(input string s);
        char_q_t text;
        for (int i = 0; i < s.len(); i++)
            text.push_back(s[i]);
        send_string(text);
    endtask

    function automatic logic [1:0] random_kind();
        case ($urandom_range(2))
            0:       return KIND_CURLY;
            1:       return KIND_SQUARE;
            default: return KIND_ROUND;
        endcase
    endfunction

    function automatic logic [7:0] open_char(input logic [1:0] kind);
        case (kind)
            KIND_CURLY:  return CH_LCURLY;
            KIND_SQUARE: return CH_LSQUARE;
            default:     return CH_LROUND;
        endcase
    endfunction

    function automatic logic [7:0] close_char(input logic [1:0] kind);
        case (kind)
            KIND_CURLY:  return CH_RCURLY;
            KIND_SQUARE: return CH_RSQUARE;
            default:     return CH_RROUND;
        endcase
    endfunction

    // Properly nested text with random kinds and random filler bytes.
    function automatic char_q_t nested_text(input int len, input int max_open);
        char_q_t    text;
        logic [1:0] kinds[$];
        logic [1:0] k;
        int         pick;
        for (int i = 0; i < len; i++)
        begin
            pick = $urandom_range(9);
            if (pick < 4 && kinds.size() < max_open)
            begin
                k = random_kind();
                kinds.push_back(k);
                text.push_back(open_char(k));
            end
            else if (pick < 8 && kinds.size() > 0)
                text.push_back(close_char(kinds.pop_back()));
            else
                text.push_back(8'($urandom_range(255)));
        end
        while (kinds.size() > 0)
            text.push_back(close_char(kinds.pop_back()));
        return text;
    endfunction

    // Damage a string: wrong closer, stray closer up front, lost character,
    // or a cut-off tail that leaves brackets open.
    function automatic char_q_t broken_text(input char_q_t text);
        int pos;
        if (text.size() == 0)
            text.push_back(open_char(random_kind()));
        pos = $urandom_range(text.size() - 1);
        case ($urandom_range(3))
            0: text[pos] = close_char(random_kind());
            1: text.push_front(close_char(random_kind()));
            2: if (text.size() > 1) text.delete(pos);
            default: while (text.size() > pos + 1) void'(text.pop_back());
        endcase
        return text;
    endfunction

    // Raw bytes, half of them forced to bracket characters.
    function automatic char_q_t noise_text(input int len);
        char_q_t text;
        for (int i = 0; i < len; i++)
        begin
            if ($urandom_range(1))
                text.push_back(8'($urandom_range(255)));
            else if ($urandom_range(1))
                text.push_back(open_char(random_kind()));
            else
                text.push_back(close_char(random_kind()));
        end
        return text;
    endfunction

    // Run of openers close to the stack capacity, then matching closers.
    function automatic char_q_t deep_text(input int n_open);
        char_q_t    text;
        logic [1:0] kinds[$];
        logic [1:0] k;
        for (int i = 0; i < n_open; i++)
        begin
            k = random_kind();
            kinds.push_back(k);
            text.push_back(open_char(k));
        end
        while (kinds.size() > 0)
            text.push_back(close_char(kinds.pop_back()));
        return text;
    endfunction

    // Result side: check each taken result, then pick the next ready level.
    initial
    begin
        bbc_result_t want;
        out_ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && out_ready)
            begin
                if (expected_results.size() == 0)
                begin
                    $error("result with no request pending: status %0d", status);
                    fail_count++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (status !== want.status)
                    begin
                        $error("status: expected %0d, got %0d", want.status, status);
                        fail_count++;
                    end
                    if (string_done !== want.done)
                    begin
                        $error("string_done: expected %0d, got %0d",
                               want.done, string_done);
                        fail_count++;
                    end
                    if (open_depth !== want.depth)
                    begin
                        $error("open_depth: expected %0d, got %0d",
                               want.depth, open_depth);
                        fail_count++;
                    end
                end
            end
            out_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Nesting, the mismatch, empty and unclosed errors, a held error, filler bytes at both extremes,
    // single-character strings and an error raised on the last character.
    task automatic test_directed();
        send_text("{[()]}");
        send_char(8'h00, 1'b0);
        send_char(8'hFF, 1'b1);
        send_text("(]x");
        send_text(")(");
        send_text("((");
        send_text("[");
        send_text("}");
        send_text("{)");
    endtask

    // Fill the stack exactly, end on a full stack, and push one past capacity.
    task automatic test_stack_limits();
        char_q_t text;
        send_string(deep_text(DEPTH));

        text.delete();
        for (int i = 0; i < DEPTH; i++)
            text.push_back(open_char(random_kind()));
        send_string(text);

        // Overflow, then closers that must be dropped while the error is held.
        text = deep_text(DEPTH + 1);
        text.push_back(8'h41);
        send_string(text);
    endtask

    // Mostly nested strings with random content, the rest damaged or raw.
    task automatic test_random_traffic(input int send_pct, input int recv_pct,
                                       input int n_items);
        int      sent;
        int      pick;
        char_q_t text;
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
        sent = 0;
        while (sent < n_items)
        begin
            pick = $urandom_range(99);
            if (pick < 60)
                text = nested_text($urandom_range(1, 30), $urandom_range(1, 12));
            else if (pick < 85)
                text = broken_text(nested_text($urandom_range(1, 30),
                                               $urandom_range(1, 12)));
            else if (pick < 95)
                text = noise_text($urandom_range(1, 10));
            else if ($urandom_range(1))
                text = deep_text($urandom_range(DEPTH - 2, DEPTH + 2));
            else
                text = broken_text(deep_text($urandom_range(DEPTH - 2, DEPTH + 2)));
            send_string(text);
            sent += text.size();
        end
    endtask

    initial
    begin
        rst_n          = 1'b0;
        in_valid       = 1'b0;
        char_code      = 8'h00;
        is_last        = 1'b0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        open_level     = 0;
        held_error     = ST_OK;
        fail_count     = 0;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        test_directed();
        test_stack_limits();
        test_random_traffic(0, 0, 270);
        test_random_traffic(51, 0, 270);
        test_random_traffic(0, 51, 270);
        test_random_traffic(23, 23, 270);

        // Drop valid and drain the results still in flight.
        in_valid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);

        if (fail_count == 0)
            $display("tb passed");
        else
            $display("tb failed");
        $finish;
    end

endmodule
